// ===== design/pcu_pkg.sv =====
// ---------------------------------------------------------------------------
// pcu_pkg: shared types, constants and the factorial table
// Holds the status codes, the tag carried through the dividers and the
// double-precision factorial table built at elaboration time.
// ---------------------------------------------------------------------------
package pcu_pkg;

  // largest factorial argument accepted
  localparam int MAX_ARGUMENT = 100;
  // index width for the factorial table
  localparam int IDX_W        = $clog2(MAX_ARGUMENT + 1);

  // double format
  localparam int DBL_W    = 64;
  localparam int FRAC_W   = 52;
  localparam int MAN_W    = FRAC_W + 1;   // with hidden one
  localparam int EXP_W    = 11;
  localparam int EXP_BIAS = 1023;
  localparam logic [DBL_W-1:0] DBL_ONE = 64'h3FF0_0000_0000_0000;

  // quotient bits per division: mantissa plus one round bit
  localparam int QBITS = MAN_W + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_B_OVER_A = 2'd1,
    ST_NEGATIVE = 2'd2,
    ST_TOO_BIG  = 2'd3
  } status_e;

  // side data that travels with an item through a divider
  typedef struct packed {
    status_e          status;
    logic [DBL_W-1:0] aux;
  } tag_t;

  typedef logic [DBL_W-1:0] fact_table_t [MAX_ARGUMENT+1];

  // n! as the double product 2*3*...*n, rounded to nearest even each step
  function automatic fact_table_t build_fact_table();
    fact_table_t       tbl;
    logic [MAN_W-1:0]  man;
    logic [MAN_W:0]    mr;
    logic [60:0]       prod;
    logic [60:0]       keep;
    logic [60:0]       mask;
    logic              rnd;
    logic              stk;
    int                ex;
    int                sh;
    int                n;
    int                i;
    man    = {1'b1, {FRAC_W{1'b0}}};
    ex     = 0;
    tbl[0] = DBL_ONE;
    for (n = 1; n <= MAX_ARGUMENT; n++) begin
      if (n >= 2) begin
        prod = 61'(man) * 61'(n);
        sh   = 0;
        for (i = 0; i <= 8; i++) begin
          if (prod[FRAC_W + i]) sh = i;
        end
        keep = prod >> sh;
        rnd  = (sh > 0) ? prod[sh-1] : 1'b0;
        if (sh > 1) begin
          mask = (61'(1) << (sh - 1)) - 61'(1);
          stk  = |(prod & mask);
        end else begin
          stk  = 1'b0;
        end
        mr = {1'b0, keep[MAN_W-1:0]};
        if (rnd && (stk || keep[0])) mr = mr + 54'(1);
        if (mr[MAN_W]) begin
          mr = mr >> 1;
          ex = ex + 1;
        end
        man = mr[MAN_W-1:0];
        ex  = ex + sh;
      end
      tbl[n] = {1'b0, EXP_W'(ex + EXP_BIAS), man[FRAC_W-1:0]};
    end
    return tbl;
  endfunction

  localparam fact_table_t FACT_TABLE = build_fact_table();

  // table read; an index past the table gives one (only on rejected items)
  function automatic logic [DBL_W-1:0] fact_bits(logic [IDX_W-1:0] n);
    logic [DBL_W-1:0] res;
    if (n > IDX_W'(MAX_ARGUMENT)) res = DBL_ONE;
    else                          res = FACT_TABLE[n];
    return res;
  endfunction

endpackage

// ===== design/pcu_div.sv =====
// ---------------------------------------------------------------------------
// pcu_div: pipelined double divider
// Restoring division, one quotient bit per stage, round to nearest even.
// Operands are positive normal doubles and the quotient stays normal.
// ---------------------------------------------------------------------------
module pcu_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [pcu_pkg::DBL_W-1:0]  dividend_i,
  input  logic [pcu_pkg::DBL_W-1:0]  divisor_i,
  input  pcu_pkg::tag_t              tag_i,
  output logic                       valid_o,
  output logic [pcu_pkg::DBL_W-1:0]  quotient_o,
  output pcu_pkg::tag_t              tag_o
);

  localparam int QB   = pcu_pkg::QBITS;
  localparam int MW   = pcu_pkg::MAN_W;
  localparam int FW   = pcu_pkg::FRAC_W;
  localparam int EW   = pcu_pkg::EXP_W;
  localparam int RW   = MW + 1;          // remainder width
  localparam int XW   = EW + 1;          // exponent work width
  localparam int DBL_W_HI = pcu_pkg::DBL_W - 2;

  logic             vld_q [QB+1];
  logic [RW-1:0]    rem_q [QB+1];
  logic [MW-1:0]    dsr_q [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic [XW-1:0]    exp_q [QB+1];
  pcu_pkg::tag_t    tag_q [QB+1];

  // setup: unpack, align dividend below twice the divisor
  logic [MW-1:0] mx, my;
  logic          lt;
  assign mx = {1'b1, dividend_i[FW-1:0]};
  assign my = {1'b1, divisor_i[FW-1:0]};
  assign lt = mx < my;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= lt ? {mx, 1'b0} : {1'b0, mx};
    dsr_q[0] <= my;
    quo_q[0] <= '0;
    exp_q[0] <= {1'b0, dividend_i[DBL_W_HI:FW]} - {1'b0, divisor_i[DBL_W_HI:FW]}
                + XW'(pcu_pkg::EXP_BIAS) - XW'(lt);
    tag_q[0] <= tag_i;
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] rnext;

    assign diff  = {1'b0, rem_q[k-1]} - {2'b00, dsr_q[k-1]};
    assign ge    = !diff[RW];
    assign rnext = ge ? diff[RW-1:0] : rem_q[k-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= {rnext[RW-2:0], 1'b0};
      dsr_q[k] <= dsr_q[k-1];
      quo_q[k] <= {quo_q[k-1][QB-2:0], ge};
      exp_q[k] <= exp_q[k-1];
      tag_q[k] <= tag_q[k-1];
    end
  end

  // rounding stage
  logic [MW-1:0]  man;
  logic           inc;
  logic [MW:0]    sum;
  logic [XW-1:0]  exp_r;
  logic [FW-1:0]  frac_r;

  assign man    = quo_q[QB][QB-1:1];
  assign inc    = quo_q[QB][0] & ((|rem_q[QB]) | man[0]);
  assign sum    = {1'b0, man} + (MW+1)'(inc);
  assign exp_r  = sum[MW] ? exp_q[QB] + XW'(1) : exp_q[QB];
  assign frac_r = sum[MW] ? '0 : sum[FW-1:0];

  logic                      out_vld_q;
  logic [pcu_pkg::DBL_W-1:0] out_q;
  pcu_pkg::tag_t             out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= {1'b0, exp_r[EW-1:0], frac_r};
    out_tag_q <= tag_q[QB];
  end

  assign valid_o    = out_vld_q;
  assign quotient_o = out_q;
  assign tag_o      = out_tag_q;

endmodule

// ===== design/permutation_combination_unit.sv =====
// ---------------------------------------------------------------------------
// permutation_combination_unit: P(a,b) and C(a,b) as IEEE doubles
// Command in (start/busy), result out as a one-cycle strobe (done_o).
// ---------------------------------------------------------------------------
// Usage:
//   An item (command_i, set_size_i, choose_size_i) is taken at a rising edge
//   with start high and busy low. busy stays low: an item may enter on every
//   cycle, one item per cycle sustained.
//   P(a,b) = a!/(a-b)! and C(a,b) = P(a,b)/b!; factorials come from a
//   constant table of doubles. Status checks in order: b above a, a
//   negative, a above limit, a-b above limit, combination with b negative.
//   result_bits_o is zero when status_o is nonzero.
//   The path runs through the input register, the check/lookup register,
//   two 56-stage dividers (setup, 54 one-bit restoring steps, rounding)
//   and the output register.
//   Each result shows for one cycle with done_o high; the receiver has no
//   way to hold it off, and the pipeline never stalls.
//   Reset clears the valid bits only; no result is invented after reset.
// ---------------------------------------------------------------------------
module permutation_combination_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [7:0]  set_size_i,
  input  logic [7:0]  choose_size_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] result_bits_o
);

  localparam int IW = pcu_pkg::IDX_W;

  assign busy = 1'b0;

  // input register
  logic              in_vld_q;
  logic              cmd_q;
  logic signed [7:0] a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= command_i;
    a_q   <= set_size_i;
    b_q   <= choose_size_i;
  end

  // checks and table lookups
  localparam logic signed [9:0] MAX_S = 10'(pcu_pkg::MAX_ARGUMENT);
  logic signed [9:0]  a_x, b_x, d_x;
  pcu_pkg::status_e   st;
  logic [63:0]        fa, fab, fb;

  assign a_x = 10'(a_q);
  assign b_x = 10'(b_q);
  assign d_x = a_x - b_x;

  always_comb begin
    priority if (b_x > a_x)            st = pcu_pkg::ST_B_OVER_A;
    else if (a_x < 10'sd0)             st = pcu_pkg::ST_NEGATIVE;
    else if (a_x > MAX_S)              st = pcu_pkg::ST_TOO_BIG;
    else if (d_x > MAX_S)              st = pcu_pkg::ST_TOO_BIG;
    else if (cmd_q && b_x < 10'sd0)    st = pcu_pkg::ST_NEGATIVE;
    else                               st = pcu_pkg::ST_OK;
  end

  assign fa  = pcu_pkg::fact_bits(a_x[IW-1:0]);
  assign fab = pcu_pkg::fact_bits(d_x[IW-1:0]);
  assign fb  = cmd_q ? pcu_pkg::fact_bits(b_x[IW-1:0]) : pcu_pkg::DBL_ONE;

  logic          lk_vld_q;
  logic [63:0]   x_q, y_q;
  pcu_pkg::tag_t lk_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_vld_q <= 1'b0;
    end else begin
      lk_vld_q <= in_vld_q;
    end
  end

  // rejected items run through the dividers as 1/1
  always_ff @(posedge clk_i) begin
    x_q             <= (st == pcu_pkg::ST_OK) ? fa  : pcu_pkg::DBL_ONE;
    y_q             <= (st == pcu_pkg::ST_OK) ? fab : pcu_pkg::DBL_ONE;
    lk_tag_q.status <= st;
    lk_tag_q.aux    <= (st == pcu_pkg::ST_OK) ? fb  : pcu_pkg::DBL_ONE;
  end

  // first division: a! / (a-b)!
  logic          d1_vld;
  logic [63:0]   d1_q;
  pcu_pkg::tag_t d1_tag;

  pcu_div u_div_perm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (lk_vld_q),
    .dividend_i (x_q),
    .divisor_i  (y_q),
    .tag_i      (lk_tag_q),
    .valid_o    (d1_vld),
    .quotient_o (d1_q),
    .tag_o      (d1_tag)
  );

  // second division: by b! for a combination, by one otherwise
  logic          d2_vld;
  logic [63:0]   d2_q;
  pcu_pkg::tag_t d2_tag;

  pcu_div u_div_comb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (d1_vld),
    .dividend_i (d1_q),
    .divisor_i  (d1_tag.aux),
    .tag_i      (d1_tag),
    .valid_o    (d2_vld),
    .quotient_o (d2_q),
    .tag_o      (d2_tag)
  );

  // output register
  logic        done_q;
  logic [1:0]  status_q;
  logic [63:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= d2_tag.status;
    result_q <= (d2_tag.status == pcu_pkg::ST_OK) ? d2_q : '0;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_bits_o = result_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for permutation_combination_unit
// Sends P(a,b) and C(a,b) items over start/busy and predicts each result
// (status and double bits) with a factorial model in real arithmetic.
// Results arrive as done_o strobes and are checked in order against a queue.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY_WAIT = 150;

  typedef struct packed {
    pcu_pkg::status_e status;
    logic [63:0]      bits;
  } npr_ncr_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [7:0]  set_size_i;
  logic [7:0]  choose_size_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] result_bits_o;

  npr_ncr_t pending_results[$];
  int       fail_count;
  bit       no_gaps;

  permutation_combination_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .set_size_i    (set_size_i),
    .choose_size_i (choose_size_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .result_bits_o (result_bits_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // n! as a double product, rounded at every step
  function automatic real factorial(int n);
    real acc;
    acc = 1.0;
    for (int k = 2; k <= n; k++) acc = acc * k;
    return acc;
  endfunction

  // expected status and value for one item
  function automatic npr_ncr_t npr_ncr(bit cmd, int a, int b);
    npr_ncr_t r;
    real      val;
    r.status = pcu_pkg::ST_OK;
    r.bits   = '0;
    if (b > a) r.status = pcu_pkg::ST_B_OVER_A;
    else if (a < 0) r.status = pcu_pkg::ST_NEGATIVE;
    else if (a > pcu_pkg::MAX_ARGUMENT) r.status = pcu_pkg::ST_TOO_BIG;
    else if (a - b > pcu_pkg::MAX_ARGUMENT) r.status = pcu_pkg::ST_TOO_BIG;
    else if (cmd && b < 0) r.status = pcu_pkg::ST_NEGATIVE;
    if (r.status == pcu_pkg::ST_OK) begin
      val = factorial(a) / factorial(a - b);
      if (cmd) val = val / factorial(b);
      r.bits = $realtobits(val);
    end
    return r;
  endfunction

  // idle length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one item and record its expected result
  task automatic send_item(bit cmd, int a, int b);
    int gap;
    start         <= 1'b1;
    command_i     <= cmd;
    set_size_i    <= 8'(a);
    choose_size_i <= 8'(b);
    do @(posedge clk_i); while (busy);
    pending_results.push_back(npr_ncr(cmd, a, b));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    npr_ncr_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d bits=%h", $time, status_o,
                 result_bits_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   want.status, status_o);
          fail_count++;
        end
        if (result_bits_o !== want.bits) begin
          $display("%0t: result_bits mismatch expected %h actual %h", $time,
                   want.bits, result_bits_o);
          fail_count++;
        end
      end
    end
  end

  // extremes, every command and every status path
  task automatic test_directed();
    for (int c = 0; c < 2; c++) begin
      send_item(c, 0, 0);
      send_item(c, 1, 0);
      send_item(c, 100, 100);
      send_item(c, 100, 0);
      send_item(c, 100, 50);
      send_item(c, 5, 6);
      send_item(c, -128, -128);
      send_item(c, -1, -1);
      send_item(c, 101, 0);
      send_item(c, 127, 127);
      send_item(c, 60, -40);
      send_item(c, 0, -101);
    end
    send_item(1'b0, 0, -100);
  endtask

  // mostly valid ranges, the rest anything in the field
  task automatic test_random(int count);
    int a;
    int b;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 9) < 7) begin
        a = $urandom_range(0, pcu_pkg::MAX_ARGUMENT);
        b = $urandom_range(0, 9) < 8 ? $urandom_range(0, a)
                                     : a - $urandom_range(0, pcu_pkg::MAX_ARGUMENT);
      end else begin
        a = $signed(8'($urandom()));
        b = $signed(8'($urandom()));
      end
      send_item($urandom_range(0, 1), a, b);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    fail_count    = 0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = 1'b0;
    set_size_i    = '0;
    choose_size_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(1000);
    wait_drained();
    test_random(925);
    wait_drained();
    repeat (LATENCY_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("permutation_combination_unit test passed");
    end else begin
      $display("permutation_combination_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("permutation_combination_unit test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
design/pcu_pkg.sv
design/pcu_div.sv
design/permutation_combination_unit.sv
tb/tb_top.sv
